[rtl/go_to_goal_velocity_controller_top_macros.svh]
// assertion macros for the go-to-goal controller checker
`ifndef GO_TO_GOAL_VELOCITY_CONTROLLER_TOP_MACROS_SVH
`define GO_TO_GOAL_VELOCITY_CONTROLLER_TOP_MACROS_SVH

// property checked only while out of reset
`define GTG_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gtg checker: property failed");

// property checked at every edge, reset included
`define GTG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("gtg checker: property failed");

`endif

[rtl/gtg_pkg.sv]
// shared types, constants and tables of the go-to-goal velocity controller
`timescale 1ns / 1ps
`default_nettype none

package gtg_pkg;

    // field widths
    localparam int POS_W   = 16;
    localparam int DIFF_W  = POS_W + 1;
    localparam int GAIN_W  = 12;
    localparam int DTOL_W  = 10;
    localparam int HTOL_W  = 13;
    localparam int LIN_W   = 20;
    localparam int ANGV_W  = 20;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // cordic
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int ATAN_IDX_W   = 5;
    localparam int ATAN_W       = 31;
    localparam int ROT_STEPS    = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int STEP_W       = $clog2(ROT_STEPS);
    localparam int GUARD_BITS   = 14;
    localparam int VEC_W        = 35;
    localparam int ZACC_W       = 34;

    // magnitude correction
    localparam int INVK_W     = 30;
    localparam int XLO_W      = 17;
    localparam int ACC_W      = VEC_W - 1 + INVK_W;
    localparam int DIST_SHIFT = 30 + GUARD_BITS;
    localparam int DIST_W     = 17;
    localparam int BEAR_SHIFT = 17;
    localparam logic [INVK_W-1:0] INV_K_Q30 = 30'd652032874;
    localparam logic signed [ZACC_W-1:0] PI_Q30 = 34'sd3373259426;

    // heading error
    localparam int ERR_W      = 19;
    localparam int WRAP_TRIES = 4;
    localparam logic signed [ERR_W-1:0] PI_Q13     = 19'sd25736;
    localparam logic signed [ERR_W-1:0] TWO_PI_Q13 = 19'sd51472;

    // gain products
    localparam int PROD_SHIFT = 8;
    localparam int ROUND_HALF = 128;
    localparam int LINS_W     = GAIN_W + DIST_W + 1;
    localparam int ANGS_W     = GAIN_W + ERR_W + 2;
    localparam logic [LIN_W-1:0] LIN_MAX = '1;

    // register reset values
    localparam logic [GAIN_W-1:0] DIST_GAIN_RST = 12'd128;
    localparam logic [GAIN_W-1:0] HEAD_GAIN_RST = 12'd512;
    localparam logic [DTOL_W-1:0] DIST_TOL_RST  = 10'd10;
    localparam logic [HTOL_W-1:0] HEAD_TOL_RST  = 13'd82;

    // job queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISTANCE_GAIN      = 2'd0,
        CFG_HEADING_GAIN       = 2'd1,
        CFG_DISTANCE_TOLERANCE = 2'd2,
        CFG_HEADING_TOLERANCE  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        CMD_GOAL  = 1'b0,
        CMD_ROBOT = 1'b1
    } t_pose_cmd;

    typedef struct packed {
        logic [GAIN_W-1:0] distance_gain;
        logic [GAIN_W-1:0] heading_gain;
        logic [DTOL_W-1:0] distance_tolerance;
        logic [HTOL_W-1:0] heading_tolerance;
    } t_cfg;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [POS_W-1:0]  heading;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_MUL_LO,
        S_MUL_HI,
        S_DIST,
        S_SCALE,
        S_OUT
    } t_back_state;

    // arctangent of 2^-i in Q30 radians, truncated
    function automatic logic [ATAN_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 31'd843314856;
            5'd1:    v = 31'd497837829;
            5'd2:    v = 31'd263043836;
            5'd3:    v = 31'd133525158;
            5'd4:    v = 31'd67021686;
            5'd5:    v = 31'd33543515;
            5'd6:    v = 31'd16775850;
            5'd7:    v = 31'd8388437;
            5'd8:    v = 31'd4194282;
            5'd9:    v = 31'd2097149;
            5'd10:   v = 31'd1048575;
            5'd11:   v = 31'd524287;
            5'd12:   v = 31'd262143;
            5'd13:   v = 31'd131071;
            5'd14:   v = 31'd65535;
            5'd15:   v = 31'd32767;
            5'd16:   v = 31'd16383;
            5'd17:   v = 31'd8191;
            5'd18:   v = 31'd4095;
            5'd19:   v = 31'd2047;
            5'd20:   v = 31'd1023;
            5'd21:   v = 31'd511;
            5'd22:   v = 31'd255;
            5'd23:   v = 31'd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/gtg_in_if.sv]
// pose update channel
`timescale 1ns / 1ps
`default_nettype none

interface gtg_in_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic signed [gtg_pkg::POS_W-1:0]  pose_x;
    logic signed [gtg_pkg::POS_W-1:0]  pose_y;
    logic signed [gtg_pkg::POS_W-1:0]  pose_heading;

    modport source (output valid, cmd, pose_x, pose_y, pose_heading, input ready);
    modport sink   (input valid, cmd, pose_x, pose_y, pose_heading, output ready);
endinterface

`default_nettype wire

[rtl/gtg_out_if.sv]
// velocity command channel
`timescale 1ns / 1ps
`default_nettype none

interface gtg_out_if;
    logic                              valid;
    logic                              ready;
    logic [gtg_pkg::LIN_W-1:0]         linear_velocity;
    logic signed [gtg_pkg::ANGV_W-1:0] angular_velocity;

    modport source (output valid, linear_velocity, angular_velocity, input ready);
    modport sink   (input valid, linear_velocity, angular_velocity, output ready);
endinterface

`default_nettype wire

[rtl/gtg_front.sv]
// front end: takes pose updates, keeps goal and robot pose, issues jobs
`timescale 1ns / 1ps
`default_nettype none

module gtg_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gtg_in_if.sink               i_in,
    input  gtg_pkg::t_q_status   i_q_status,
    output logic                 o_push,
    output gtg_pkg::t_job        o_job
);

    logic signed [gtg_pkg::POS_W-1:0] r_goal_x, r_goal_y;
    logic signed [gtg_pkg::POS_W-1:0] r_robot_x, r_robot_y, r_robot_heading;
    logic                             r_goal_seen, r_robot_seen;

    logic signed [gtg_pkg::POS_W-1:0] n_goal_x, n_goal_y;
    logic signed [gtg_pkg::POS_W-1:0] n_robot_x, n_robot_y, n_robot_heading;
    logic                             n_goal_seen, n_robot_seen;
    logic                             accept;
    logic                             is_robot;

    // accept while the queue has room
    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && !i_q_status.full;
    assign is_robot   = (i_in.cmd == gtg_pkg::CMD_ROBOT);

    // pose state after this beat
    always_comb begin
        n_goal_x        = r_goal_x;
        n_goal_y        = r_goal_y;
        n_robot_x       = r_robot_x;
        n_robot_y       = r_robot_y;
        n_robot_heading = r_robot_heading;
        n_goal_seen     = r_goal_seen;
        n_robot_seen    = r_robot_seen;
        if (accept) begin
            if (is_robot) begin
                n_robot_x       = i_in.pose_x;
                n_robot_y       = i_in.pose_y;
                n_robot_heading = i_in.pose_heading;
                n_robot_seen    = 1'b1;
            end else begin
                n_goal_x    = i_in.pose_x;
                n_goal_y    = i_in.pose_y;
                n_goal_seen = 1'b1;
            end
        end
    end

    // job issue once both poses are known
    assign o_push        = accept && n_goal_seen && n_robot_seen;
    assign o_job.dx      = gtg_pkg::DIFF_W'(n_goal_x) - gtg_pkg::DIFF_W'(n_robot_x);
    assign o_job.dy      = gtg_pkg::DIFF_W'(n_goal_y) - gtg_pkg::DIFF_W'(n_robot_y);
    assign o_job.heading = n_robot_heading;

    // seen flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_seen  <= 1'b0;
            r_robot_seen <= 1'b0;
        end else begin
            r_goal_seen  <= n_goal_seen;
            r_robot_seen <= n_robot_seen;
        end
    end

    // pose registers
    always_ff @(posedge i_clk) begin
        r_goal_x        <= n_goal_x;
        r_goal_y        <= n_goal_y;
        r_robot_x       <= n_robot_x;
        r_robot_y       <= n_robot_y;
        r_robot_heading <= n_robot_heading;
    end

endmodule

`default_nettype wire

[rtl/gtg_queue.sv]
// short job queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module gtg_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  gtg_pkg::t_job        i_job,
    input  logic                 i_pop,
    output gtg_pkg::t_job        o_job,
    output gtg_pkg::t_q_status   o_status
);

    gtg_pkg::t_job                     r_mem [gtg_pkg::QUEUE_DEPTH];
    logic [gtg_pkg::QUEUE_AW-1:0]      r_wr, r_rd;
    logic [gtg_pkg::QUEUE_CNT_W-1:0]   r_cnt;
    logic [gtg_pkg::QUEUE_AW-1:0]      n_wr, n_rd;
    logic [gtg_pkg::QUEUE_CNT_W-1:0]   n_cnt;

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == gtg_pkg::QUEUE_AW'(gtg_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == gtg_pkg::QUEUE_AW'(gtg_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_job          = r_mem[r_rd];
    assign o_status.full  = (r_cnt == gtg_pkg::QUEUE_CNT_W'(gtg_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);

endmodule

`default_nettype wire

[rtl/gtg_back.sv]
// back end: iterative cordic, magnitude correction, heading error, gains
`timescale 1ns / 1ps
`default_nettype none

module gtg_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gtg_pkg::t_cfg        i_cfg,
    input  gtg_pkg::t_q_status   i_q_status,
    input  gtg_pkg::t_job        i_job,
    output logic                 o_pop,
    gtg_out_if.source            o_out
);

    gtg_pkg::t_back_state                  r_state, n_state;
    logic [gtg_pkg::STEP_W-1:0]            r_step, n_step;
    logic signed [gtg_pkg::VEC_W-1:0]      r_x, r_y, n_x, n_y;
    logic signed [gtg_pkg::ZACC_W-1:0]     r_z, n_z;
    logic                                  r_zero, n_zero;
    logic signed [gtg_pkg::POS_W-1:0]      r_heading, n_heading;
    logic [gtg_pkg::ACC_W-1:0]             r_acc, n_acc;
    logic signed [gtg_pkg::ERR_W-1:0]      r_err, n_err;
    logic [gtg_pkg::DIST_W-1:0]            r_dist, n_dist;
    logic [gtg_pkg::LIN_W-1:0]             r_res_lin, n_res_lin;
    logic [gtg_pkg::ANGV_W-1:0]            r_res_ang, n_res_ang;
    logic                                  r_out_valid;
    logic [gtg_pkg::LIN_W-1:0]             r_out_lin;
    logic [gtg_pkg::ANGV_W-1:0]            r_out_ang;

    logic                                  out_free;
    logic                                  load_out;
    logic                                  dx_neg;
    logic signed [gtg_pkg::DIFF_W:0]       dx_pre, dy_pre;
    logic signed [gtg_pkg::VEC_W-1:0]      x_sh, y_sh;
    logic signed [gtg_pkg::ZACC_W-1:0]     atan_ext;
    logic [gtg_pkg::VEC_W-2:0]             x_pos;
    logic [gtg_pkg::XLO_W-1:0]             mul_a;
    logic [gtg_pkg::XLO_W+gtg_pkg::INVK_W-1:0] prod;
    logic [gtg_pkg::ACC_W-1:0]             dist_sum;
    logic signed [gtg_pkg::ZACC_W-1:0]     z_round;
    logic signed [gtg_pkg::ZACC_W-gtg_pkg::BEAR_SHIFT-1:0] bearing;
    logic signed [gtg_pkg::ERR_W-1:0]      err_wrap;
    logic [gtg_pkg::ERR_W-1:0]             aerr;
    logic                                  near;
    logic [gtg_pkg::GAIN_W+gtg_pkg::DIST_W-1:0] lin_prod;
    logic [gtg_pkg::LINS_W-1:0]            lin_sum;
    logic [gtg_pkg::LINS_W-gtg_pkg::PROD_SHIFT-1:0] lin_q;
    logic signed [gtg_pkg::GAIN_W+gtg_pkg::ERR_W:0] ang_prod;
    logic signed [gtg_pkg::ANGS_W-1:0]     ang_sum;

    assign out_free = !r_out_valid || o_out.ready;
    assign load_out = (r_state == gtg_pkg::S_OUT) && out_free;
    assign o_pop    = (r_state == gtg_pkg::S_IDLE) && !i_q_status.empty;

    // pre-rotation into the right half plane
    assign dx_neg = i_job.dx[gtg_pkg::DIFF_W-1];
    assign dx_pre = dx_neg ? -(gtg_pkg::DIFF_W'(1)'(0) + (gtg_pkg::DIFF_W + 1)'(i_job.dx))
                           : (gtg_pkg::DIFF_W + 1)'(i_job.dx);
    assign dy_pre = dx_neg ? -((gtg_pkg::DIFF_W + 1)'(i_job.dy))
                           : (gtg_pkg::DIFF_W + 1)'(i_job.dy);

    // one cordic micro-rotation
    assign x_sh     = r_x >>> r_step;
    assign y_sh     = r_y >>> r_step;
    assign atan_ext = $signed({{(gtg_pkg::ZACC_W - gtg_pkg::ATAN_W){1'b0}},
                               gtg_pkg::atan_q30(gtg_pkg::ATAN_IDX_W'(r_step))});

    // shared magnitude multiplier, low half then high half
    assign x_pos = r_x[gtg_pkg::VEC_W-1] ? '0 : r_x[gtg_pkg::VEC_W-2:0];
    assign mul_a = (r_state == gtg_pkg::S_MUL_HI) ? x_pos[gtg_pkg::VEC_W-2:gtg_pkg::XLO_W]
                                                  : x_pos[gtg_pkg::XLO_W-1:0];
    assign prod  = mul_a * gtg_pkg::INV_K_Q30;

    // rounding of distance and bearing
    assign dist_sum = r_acc + (gtg_pkg::ACC_W'(1) << (gtg_pkg::DIST_SHIFT - 1));
    assign z_round  = r_z + (gtg_pkg::ZACC_W'(1) << (gtg_pkg::BEAR_SHIFT - 1));
    assign bearing  = r_zero ? '0 : $signed(z_round[gtg_pkg::ZACC_W-1:gtg_pkg::BEAR_SHIFT]);

    // heading error wrap into (-pi, pi]
    always_comb begin
        err_wrap = r_err;
        for (int k = 0; k < gtg_pkg::WRAP_TRIES; k++) begin
            if (err_wrap > gtg_pkg::PI_Q13) begin
                err_wrap = err_wrap - gtg_pkg::TWO_PI_Q13;
            end
        end
        for (int k = 0; k < gtg_pkg::WRAP_TRIES; k++) begin
            if (err_wrap <= -gtg_pkg::PI_Q13) begin
                err_wrap = err_wrap + gtg_pkg::TWO_PI_Q13;
            end
        end
    end

    // gains, saturation and stop window
    assign aerr     = r_err[gtg_pkg::ERR_W-1] ? gtg_pkg::ERR_W'(-r_err) : gtg_pkg::ERR_W'(r_err);
    assign near     = (r_dist < gtg_pkg::DIST_W'(i_cfg.distance_tolerance)) &&
                      (aerr < gtg_pkg::ERR_W'(i_cfg.heading_tolerance));
    assign lin_prod = i_cfg.distance_gain * r_dist;
    assign lin_sum  = gtg_pkg::LINS_W'(lin_prod) + gtg_pkg::LINS_W'(gtg_pkg::ROUND_HALF);
    assign lin_q    = lin_sum[gtg_pkg::LINS_W-1:gtg_pkg::PROD_SHIFT];
    assign ang_prod = $signed({1'b0, i_cfg.heading_gain}) * r_err;
    assign ang_sum  = gtg_pkg::ANGS_W'(ang_prod) + gtg_pkg::ANGS_W'(gtg_pkg::ROUND_HALF);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gtg_pkg::S_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = gtg_pkg::S_ROT;
                end
            end
            gtg_pkg::S_ROT: begin
                if (r_step == gtg_pkg::STEP_W'(gtg_pkg::ROT_STEPS - 1)) begin
                    n_state = gtg_pkg::S_MUL_LO;
                end
            end
            gtg_pkg::S_MUL_LO: n_state = gtg_pkg::S_MUL_HI;
            gtg_pkg::S_MUL_HI: n_state = gtg_pkg::S_DIST;
            gtg_pkg::S_DIST:   n_state = gtg_pkg::S_SCALE;
            gtg_pkg::S_SCALE:  n_state = gtg_pkg::S_OUT;
            gtg_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = gtg_pkg::S_IDLE;
                end
            end
            default: n_state = gtg_pkg::S_IDLE;
        endcase
    end

    // datapath per state
    always_comb begin
        n_step    = r_step;
        n_x       = r_x;
        n_y       = r_y;
        n_z       = r_z;
        n_zero    = r_zero;
        n_heading = r_heading;
        n_acc     = r_acc;
        n_err     = r_err;
        n_dist    = r_dist;
        n_res_lin = r_res_lin;
        n_res_ang = r_res_ang;
        case (r_state)
            gtg_pkg::S_IDLE: begin
                n_step    = '0;
                n_zero    = (i_job.dx == '0) && (i_job.dy == '0);
                n_heading = i_job.heading;
                n_x       = gtg_pkg::VEC_W'(dx_pre) <<< gtg_pkg::GUARD_BITS;
                n_y       = gtg_pkg::VEC_W'(dy_pre) <<< gtg_pkg::GUARD_BITS;
                if (!dx_neg) begin
                    n_z = '0;
                end else if (!i_job.dy[gtg_pkg::DIFF_W-1]) begin
                    n_z = gtg_pkg::PI_Q30;
                end else begin
                    n_z = -gtg_pkg::PI_Q30;
                end
            end
            gtg_pkg::S_ROT: begin
                n_step = r_step + 1'b1;
                if (r_y > 0) begin
                    n_x = r_x + y_sh;
                    n_y = r_y - x_sh;
                    n_z = r_z + atan_ext;
                end else begin
                    n_x = r_x - y_sh;
                    n_y = r_y + x_sh;
                    n_z = r_z - atan_ext;
                end
            end
            gtg_pkg::S_MUL_LO: begin
                n_acc = gtg_pkg::ACC_W'(prod);
                n_err = gtg_pkg::ERR_W'(bearing) - gtg_pkg::ERR_W'(r_heading);
            end
            gtg_pkg::S_MUL_HI: begin
                n_acc = r_acc + (gtg_pkg::ACC_W'(prod) << gtg_pkg::XLO_W);
                n_err = err_wrap;
            end
            gtg_pkg::S_DIST: begin
                n_dist = r_zero ? '0 : dist_sum[gtg_pkg::DIST_SHIFT +: gtg_pkg::DIST_W];
            end
            gtg_pkg::S_SCALE: begin
                if (near) begin
                    n_res_lin = '0;
                    n_res_ang = '0;
                end else begin
                    n_res_lin = (lin_q > gtg_pkg::LINS_W'(gtg_pkg::LIN_MAX)) ? gtg_pkg::LIN_MAX
                                : lin_q[gtg_pkg::LIN_W-1:0];
                    n_res_ang = ang_sum[gtg_pkg::PROD_SHIFT +: gtg_pkg::ANGV_W];
                end
            end
            default: begin
                n_step = r_step;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gtg_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_step    <= n_step;
        r_x       <= n_x;
        r_y       <= n_y;
        r_z       <= n_z;
        r_zero    <= n_zero;
        r_heading <= n_heading;
        r_acc     <= n_acc;
        r_err     <= n_err;
        r_dist    <= n_dist;
        r_res_lin <= n_res_lin;
        r_res_ang <= n_res_ang;
        if (load_out) begin
            r_out_lin <= r_res_lin;
            r_out_ang <= r_res_ang;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.linear_velocity  = r_out_lin;
    assign o_out.angular_velocity = $signed(r_out_ang);

endmodule

`default_nettype wire

[rtl/go_to_goal_velocity_controller_top.sv]
// top level of the go-to-goal velocity controller
// Pose updates come in on i_in (valid/ready): cmd low sets the goal x/y,
// cmd high sets the robot x/y and heading. Once both kinds have been seen,
// every accepted beat yields one velocity command beat on o_out
// (linear_velocity Q10.10 unsigned, angular_velocity Q7.13 signed).
// Gains and stop tolerances are written through i_cfg_we/i_cfg_idx/i_cfg_data
// only while the block is idle: a rule for the user that the block itself
// does not enforce; one write per cycle, no read-back.
// Each job runs the 16-step iterative cordic, then its finishing steps
// (two-pass magnitude multiply, rounding, gains, output load); the back end
// takes no new job until the last is done. A two-entry job queue lets the
// front take two more beats while the back end works.
// Reset (synchronous, active low) clears both seen flags, empties the queue,
// drops o_out.valid and restores register defaults (gains 0.5 and 2.0).
// When the receiver stalls, the command is held on o_out; the back end then
// waits, the queue fills and i_in.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module go_to_goal_velocity_controller_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gtg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gtg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    gtg_in_if.sink                            i_in,
    gtg_out_if.source                         o_out
);

    gtg_pkg::t_cfg      r_cfg, n_cfg;
    gtg_pkg::t_q_status q_status;
    gtg_pkg::t_job      push_job, head_job;
    logic               push, pop;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (gtg_pkg::t_cfg_idx'(i_cfg_idx))
                gtg_pkg::CFG_DISTANCE_GAIN:
                    n_cfg.distance_gain = i_cfg_data[gtg_pkg::GAIN_W-1:0];
                gtg_pkg::CFG_HEADING_GAIN:
                    n_cfg.heading_gain = i_cfg_data[gtg_pkg::GAIN_W-1:0];
                gtg_pkg::CFG_DISTANCE_TOLERANCE:
                    n_cfg.distance_tolerance = i_cfg_data[gtg_pkg::DTOL_W-1:0];
                gtg_pkg::CFG_HEADING_TOLERANCE:
                    n_cfg.heading_tolerance = i_cfg_data[gtg_pkg::HTOL_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.distance_gain      <= gtg_pkg::DIST_GAIN_RST;
            r_cfg.heading_gain       <= gtg_pkg::HEAD_GAIN_RST;
            r_cfg.distance_tolerance <= gtg_pkg::DIST_TOL_RST;
            r_cfg.heading_tolerance  <= gtg_pkg::HEAD_TOL_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // front end
    gtg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    // job queue
    gtg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    // back end
    gtg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_status (q_status),
        .i_job      (head_job),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

[rtl/gtg_checker.sv]
// port-level checker for the go-to-goal controller, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "go_to_goal_velocity_controller_top_macros.svh"

module gtg_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [gtg_pkg::LIN_W-1:0]         i_lin,
    input  logic [gtg_pkg::ANGV_W-1:0]        i_ang
);

    logic in_stalled;

    assign in_stalled = i_in_valid && !i_in_ready;

    // reset empties the output register
    `GTG_ASSERT_ALWAYS(a_no_out_after_reset, i_clk, !i_rst_n |=> !i_out_valid)

    // the job queue is empty right after reset, so input is open
    `GTG_ASSERT_ALWAYS(a_ready_after_reset, i_clk, !i_rst_n |=> i_in_ready)

    // a stalled command stays offered
    `GTG_ASSERT_RST(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)

    // a stalled command keeps its payload
    `GTG_ASSERT_RST(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready && !in_stalled |=> $stable(i_lin) && $stable(i_ang))

endmodule

bind go_to_goal_velocity_controller_top gtg_checker u_gtg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_lin       (o_out.linear_velocity),
    .i_ang       (o_out.angular_velocity)
);

`default_nettype wire

[tb/sv/testbench.sv]
// testbench for the go-to-goal velocity controller: directed script, random poses, scoreboard
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import gtg_pkg::*;

    // timing and run limits
    localparam int DRAIN_CYCLES   = 48;
    localparam int STALL_LIMIT    = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 163;
    localparam int SIDE_SEND      = 0;
    localparam int SIDE_RECV      = 1;

    // fixed point constants of the control law
    localparam int     ROTATIONS   = 16;
    localparam int     PRESCALE    = 14;
    localparam longint HALF_TURN   = 25736;
    localparam longint FULL_TURN   = 51472;
    localparam longint HALF_TURN_Z = 64'sd3373259426;
    localparam longint GAIN_RECIP  = 64'sd652032874;
    localparam longint LIN_CEIL    = 1048575;

    typedef enum logic [1:0] {
        ROW_POSE,
        ROW_SILENT,
        ROW_LITERAL,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind                kind;
        t_pose_cmd                cmd;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [POS_W-1:0]  h;
        logic [LIN_W-1:0]         lin;
        logic [ANGV_W-1:0]        ang;
        t_cfg_idx                 reg_idx;
        logic [CFG_DATA_W-1:0]    reg_val;
    } t_script_row;

    typedef struct packed {
        logic [LIN_W-1:0]  lin;
        logic [ANGV_W-1:0] ang;
    } t_velocity;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    gtg_in_if  in_if ();
    gtg_out_if out_if ();

    go_to_goal_velocity_controller_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // tracked controller state and registers
    logic signed [POS_W-1:0] goal_x_q, goal_y_q;
    logic signed [POS_W-1:0] robot_x_q, robot_y_q, robot_h_q;
    bit                      goal_seen_q, robot_seen_q;
    longint                  dist_gain_q, head_gain_q, dist_tol_q, head_tol_q;

    longint arctan_q30 [0:23] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127
    };

    t_velocity   velocity_due [$];
    t_script_row script [$];
    int          fault_count;
    int          quiet_cycles;
    int          wait_left [2];
    bit          wait_quiet [2];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // per-side wait, with stretches of back-to-back beats
    function automatic int draw_wait(input int side);
        if (wait_left[side] == 0) begin
            wait_left[side]  = $urandom_range(1, 40);
            wait_quiet[side] = ($urandom_range(0, 3) == 0);
        end
        wait_left[side] = wait_left[side] - 1;
        return wait_quiet[side] ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(input int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[POS_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] edge_pos();
        case ($urandom_range(0, 3))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return 16'sd0;
            default: return -16'sd1;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_setting();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return $urandom_range(0, 8191);
        endcase
    endfunction

    task automatic note_fault(input string what);
        fault_count = fault_count + 1;
        if (fault_count <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // vectoring cordic: distance in Q7.10 and bearing in Q3.13
    task automatic cordic_polar(input longint dx, input longint dy,
                                output longint distance, output longint bearing);
        longint x, y, z, nx, ny;
        int     i;
        if (dx == 0 && dy == 0) begin
            distance = 0;
            bearing  = 0;
        end else begin
            z = 0;
            // left half plane: start from plus or minus pi
            if (dx < 0) begin
                z  = (dy >= 0) ? HALF_TURN_Z : -HALF_TURN_Z;
                dx = -dx;
                dy = -dy;
            end
            x = dx * (64'sd1 <<< PRESCALE);
            y = dy * (64'sd1 <<< PRESCALE);
            for (i = 0; i < ROTATIONS; i++) begin
                if (y > 0) begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z  = z + arctan_q30[i];
                end else begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z  = z - arctan_q30[i];
                end
                x = nx;
                y = ny;
            end
            if (x < 0)
                x = 0;
            distance = (x * GAIN_RECIP + (64'sd1 <<< (29 + PRESCALE))) >>> (30 + PRESCALE);
            bearing  = (z + (64'sd1 <<< 16)) >>> 17;
        end
    endtask

    // apply one pose beat and work out the velocity command it causes
    task automatic predict_command(input t_pose_cmd c, input logic signed [POS_W-1:0] px,
                                   input logic signed [POS_W-1:0] py,
                                   input logic signed [POS_W-1:0] ph,
                                   output bit produced, output t_velocity v);
        longint distance, bearing, err, aerr, lin, ang;
        int     i;
        if (c == CMD_GOAL) begin
            goal_x_q    = px;
            goal_y_q    = py;
            goal_seen_q = 1'b1;
        end else begin
            robot_x_q    = px;
            robot_y_q    = py;
            robot_h_q    = ph;
            robot_seen_q = 1'b1;
        end
        produced = goal_seen_q && robot_seen_q;
        v = '0;
        if (produced) begin
            cordic_polar(longint'(goal_x_q) - longint'(robot_x_q),
                         longint'(goal_y_q) - longint'(robot_y_q), distance, bearing);
            // heading error wrapped into (-pi, pi]
            err = bearing - longint'(robot_h_q);
            for (i = 0; i < 4 && err > HALF_TURN; i++)
                err = err - FULL_TURN;
            for (i = 0; i < 4 && err <= -HALF_TURN; i++)
                err = err + FULL_TURN;
            aerr = (err < 0) ? -err : err;
            // stop inside both tolerances, else proportional law
            if (distance < dist_tol_q && aerr < head_tol_q) begin
                lin = 0;
                ang = 0;
            end else begin
                lin = (dist_gain_q * distance + 128) >>> 8;
                if (lin > LIN_CEIL)
                    lin = LIN_CEIL;
                ang = (head_gain_q * err + 128) >>> 8;
            end
            v.lin = lin[LIN_W-1:0];
            v.ang = ang[ANGV_W-1:0];
        end
    endtask

    task automatic add_pose(input t_row_kind kind, input t_pose_cmd c, input int x,
                            input int y, input int h, input int lin, input int ang);
        t_script_row row;
        row         = '0;
        row.kind    = kind;
        row.cmd     = c;
        row.x       = x[POS_W-1:0];
        row.y       = y[POS_W-1:0];
        row.h       = h[POS_W-1:0];
        row.lin     = lin[LIN_W-1:0];
        row.ang     = ang[ANGV_W-1:0];
        script.push_back(row);
    endtask

    task automatic add_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        t_script_row row;
        row         = '0;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = val;
        script.push_back(row);
    endtask

    // register write; the caller lowers the write enable after the last one
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_DISTANCE_GAIN:      dist_gain_q = val[GAIN_W-1:0];
            CFG_HEADING_GAIN:       head_gain_q = val[GAIN_W-1:0];
            CFG_DISTANCE_TOLERANCE: dist_tol_q  = val[DTOL_W-1:0];
            CFG_HEADING_TOLERANCE:  head_tol_q  = val[HTOL_W-1:0];
            default: ;
        endcase
    endtask

    // wait until every command has come out and the back end is quiet
    task automatic settle();
        in_if.valid <= 1'b0;
        while (velocity_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] dg, input logic [CFG_DATA_W-1:0] hg,
                                  input logic [CFG_DATA_W-1:0] dt, input logic [CFG_DATA_W-1:0] ht);
        settle();
        write_reg(CFG_DISTANCE_GAIN, dg);
        write_reg(CFG_HEADING_GAIN, hg);
        write_reg(CFG_DISTANCE_TOLERANCE, dt);
        write_reg(CFG_HEADING_TOLERANCE, ht);
        i_cfg_we <= 1'b0;
    endtask

    // present one pose beat and return at the edge that takes it
    task automatic send_pose(input t_pose_cmd c, input logic signed [POS_W-1:0] x,
                             input logic signed [POS_W-1:0] y, input logic signed [POS_W-1:0] h);
        int gap;
        gap = draw_wait(SIDE_SEND);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.cmd          <= c;
        in_if.pose_x       <= x;
        in_if.pose_y       <= y;
        in_if.pose_heading <= h;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // random pose: wide, near zero, near the other pose, on the edges, wild heading
    task automatic pick_random_pose(output t_pose_cmd c, output logic signed [POS_W-1:0] x,
                                    output logic signed [POS_W-1:0] y,
                                    output logic signed [POS_W-1:0] h);
        logic signed [POS_W-1:0] bx, by;
        longint                  distance, bearing;
        int                      ox, oy, oh;
        c  = $urandom_range(0, 1) ? CMD_ROBOT : CMD_GOAL;
        x  = $urandom;
        y  = $urandom;
        h  = $urandom_range(0, 51472) - 25736;
        bx = (c == CMD_ROBOT) ? goal_x_q : robot_x_q;
        by = (c == CMD_ROBOT) ? goal_y_q : robot_y_q;
        ox = $urandom_range(0, 32) - 16;
        oy = $urandom_range(0, 32) - 16;
        oh = $urandom_range(0, 400) - 200;
        case ($urandom_range(0, 9))
            3, 4: begin
                x = $urandom_range(0, 128) - 64;
                y = $urandom_range(0, 128) - 64;
            end
            5, 6: begin
                x = clamp_pos(int'(bx) + ox);
                y = clamp_pos(int'(by) + oy);
                // robot near the goal and pointing roughly at it
                if (c == CMD_ROBOT) begin
                    cordic_polar(longint'(goal_x_q) - longint'(x),
                                 longint'(goal_y_q) - longint'(y), distance, bearing);
                    h = bearing + oh;
                end
            end
            7: begin
                x = bx;
                y = by;
            end
            8: begin
                x = edge_pos();
                y = edge_pos();
            end
            9: h = $urandom;
            default: ;
        endcase
    endtask

    // receiver: random back-pressure
    initial begin : recv_side
        int stall;
        out_if.ready <= 1'b0;
        forever begin
            stall = draw_wait(SIDE_RECV);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
        end
    end

    // scoreboard on the command channel
    always @(posedge i_clk) begin : check_out
        t_velocity got, want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.lin = out_if.linear_velocity;
            got.ang = out_if.angular_velocity;
            if (velocity_due.size() == 0) begin
                note_fault($sformatf("unexpected command lin=%0d ang=%0d",
                                     got.lin, $signed(got.ang)));
            end else begin
                want = velocity_due.pop_front();
                if (got.lin !== want.lin)
                    note_fault($sformatf("linear_velocity expected %0d got %0d",
                                         want.lin, got.lin));
                if (got.ang !== want.ang)
                    note_fault($sformatf("angular_velocity expected %0d got %0d",
                                         $signed(want.ang), $signed(got.ang)));
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // main stimulus
    initial begin : stimulus
        t_script_row             row;
        t_velocity               v;
        bit                      produced;
        bit                      cfg_open;
        t_pose_cmd               c;
        logic signed [POS_W-1:0] px, py, ph;
        int                      r, p, k;

        fault_count  = 0;
        quiet_cycles = 0;
        wait_left    = '{0, 0};
        wait_quiet   = '{0, 0};
        cfg_open     = 1'b0;

        // state after reset
        goal_x_q     = '0;
        goal_y_q     = '0;
        robot_x_q    = '0;
        robot_y_q    = '0;
        robot_h_q    = '0;
        goal_seen_q  = 1'b0;
        robot_seen_q = 1'b0;
        dist_gain_q  = 128;
        head_gain_q  = 512;
        dist_tol_q   = 10;
        head_tol_q   = 82;

        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_DISTANCE_GAIN;
        i_cfg_data         <= '0;
        in_if.valid        <= 1'b0;
        in_if.cmd          <= CMD_GOAL;
        in_if.pose_x       <= '0;
        in_if.pose_y       <= '0;
        in_if.pose_heading <= '0;

        // directed script
        add_pose(ROW_SILENT,  CMD_GOAL,  0, 0, 0, 0, 0);
        add_pose(ROW_LITERAL, CMD_ROBOT, 0, 0, 0, 0, 0);
        add_pose(ROW_LITERAL, CMD_ROBOT, 0, 0, 8192, 0, -16384);
        add_pose(ROW_LITERAL, CMD_ROBOT, 0, 0, -25736, 0, 51472);
        add_pose(ROW_LITERAL, CMD_ROBOT, 0, 0, 25736, 0, 51472);
        add_pose(ROW_LITERAL, CMD_ROBOT, 0, 0, 32767, 0, 37410);
        add_pose(ROW_LITERAL, CMD_ROBOT, 0, 0, -32768, 0, -37408);
        add_pose(ROW_POSE, CMD_GOAL,  32767, 32767, 0, 0, 0);
        add_pose(ROW_POSE, CMD_ROBOT, -32768, -32768, 0, 0, 0);
        add_pose(ROW_POSE, CMD_ROBOT, 100, 0, 0, 0, 0);
        add_pose(ROW_POSE, CMD_GOAL,  -32768, 0, 0, 0, 0);
        add_pose(ROW_POSE, CMD_GOAL,  -32768, -5, 0, 0, 0);
        add_pose(ROW_POSE, CMD_GOAL,  -32768, 32767, 0, 0, 0);
        add_pose(ROW_POSE, CMD_GOAL,  32767, -32768, 0, 0, 0);
        add_pose(ROW_POSE, CMD_ROBOT, -32768, 32767, 12345, 0, 0);
        add_pose(ROW_POSE, CMD_GOAL,  5, 3, 0, 0, 0);
        add_pose(ROW_POSE, CMD_ROBOT, 0, 0, 4427, 0, 0);
        add_pose(ROW_POSE, CMD_GOAL,  0, -700, 0, 0, 0);
        add_write(CFG_DISTANCE_GAIN, '1);
        add_write(CFG_HEADING_GAIN, '1);
        add_write(CFG_DISTANCE_TOLERANCE, '1);
        add_write(CFG_HEADING_TOLERANCE, '1);
        add_pose(ROW_POSE, CMD_GOAL,  32767, 32767, 0, 0, 0);
        add_pose(ROW_POSE, CMD_ROBOT, -32768, -32768, -25736, 0, 0);
        add_write(CFG_DISTANCE_GAIN, '0);
        add_write(CFG_HEADING_GAIN, '0);
        add_write(CFG_DISTANCE_TOLERANCE, '0);
        add_write(CFG_HEADING_TOLERANCE, '0);
        add_pose(ROW_LITERAL, CMD_ROBOT, 0, 0, 1000, 0, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // walk the script
        for (r = 0; r < script.size(); r++) begin
            row = script[r];
            if (row.kind == ROW_WRITE) begin
                if (!cfg_open)
                    settle();
                write_reg(row.reg_idx, row.reg_val);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) begin
                    i_cfg_we <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_pose(row.cmd, row.x, row.y, row.h);
                predict_command(row.cmd, row.x, row.y, row.h, produced, v);
                if (row.kind == ROW_LITERAL) begin
                    v.lin = row.lin;
                    v.ang = row.ang;
                    velocity_due.push_back(v);
                end else if (row.kind == ROW_POSE && produced) begin
                    velocity_due.push_back(v);
                end
            end
        end

        // random phases, each under its own register settings
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       apply_settings('1, '1, '1, '1);
                1:       apply_settings('0, '0, '0, '0);
                2:       apply_settings(DIST_GAIN_RST, HEAD_GAIN_RST, DIST_TOL_RST, HEAD_TOL_RST);
                default: apply_settings(pick_setting(), pick_setting(),
                                        pick_setting(), pick_setting());
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) begin
                pick_random_pose(c, px, py, ph);
                send_pose(c, px, py, ph);
                predict_command(c, px, py, ph, produced, v);
                if (produced)
                    velocity_due.push_back(v);
            end
        end

        settle();
        if (fault_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl
rtl/gtg_pkg.sv
rtl/gtg_in_if.sv
rtl/gtg_out_if.sv
rtl/gtg_front.sv
rtl/gtg_queue.sv
rtl/gtg_back.sv
rtl/go_to_goal_velocity_controller_top.sv
rtl/gtg_checker.sv
tb/sv/testbench.sv
